/* hw/rtl/tos_pkg.sv */
// Shared types, constants and match functions for the TCP option stripper.
// No dependencies; every other file in the block imports this package.
package tos_pkg;

  localparam logic [7:0] EOL_BYTE   = 8'd0;
  localparam logic [7:0] NOP_BYTE   = 8'd1;
  localparam logic [7:0] MPTCP_KIND = 8'd30;
  localparam logic [5:0] MAX_AREA   = 6'd40;
  localparam int KIND_SLOTS    = 8;
  localparam int SUBTYPE_SLOTS = 8;
  // result queue depth: power of two, 4 to 32
  localparam int OQ_DEPTH      = 8;

  typedef enum logic [2:0] {
    CFG_KIND_LIST     = 3'd0,
    CFG_KIND_COUNT    = 3'd1,
    CFG_SUBTYPE_LIST  = 3'd2,
    CFG_SUBTYPE_COUNT = 3'd3,
    CFG_STRIP_SYN     = 3'd4,
    CFG_STRIP_DATA    = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_KIND = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_SUB  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       seg_start;
    logic [5:0] area_len;
    logic       syn_flag;
  } tos_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       seg_last;
    logic       was_changed;
  } tos_out_t;

  typedef struct packed {
    logic [1:0]         cnt;
    tos_out_t [2:0]     res;
  } tos_push_t;

  typedef struct packed {
    logic [63:0] kind_list;
    logic [3:0]  kind_count;
    logic [31:0] subtype_list;
    logic [3:0]  subtype_count;
    logic        strip_on_syn;
    logic        strip_on_data;
  } tos_cfg_t;

  function automatic logic kind_hit(logic [63:0] list, logic [3:0] cnt, logic [7:0] k);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KIND_SLOTS; i++) begin
      if (4'(i) < cnt && list[8*i +: 8] == k) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic subtype_hit(logic [31:0] list, logic [3:0] cnt, logic [3:0] s);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SUBTYPE_SLOTS; i++) begin
      if (4'(i) < cnt && list[4*i +: 4] == s) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic tos_out_t mk_res(logic [7:0] b, logic last, logic rm);
    tos_out_t r;
    r.out_byte    = rm ? NOP_BYTE : b;
    r.seg_last    = last;
    r.was_changed = rm;
    return r;
  endfunction

endpackage

/* hw/rtl/tcp_option_stripper_core.sv */
// TCP option stripper top level: config registers, parser, result queue.
// Path: an accepted byte enters the input register, is parsed, then goes to the result queue.
// Throughput: one byte per cycle; in_stall rises only when the result queue has
// fewer than three free entries (a byte may release up to three held results).
// Reset: synchronous, active low; clears segment and queue state, config to defaults.
module tcp_option_stripper_core #(
  parameter int QUEUE_DEPTH = tos_pkg::OQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tos_pkg::tos_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tos_pkg::tos_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_wdata
);
  import tos_pkg::*;

  tos_cfg_t  cfg;
  tos_push_t push;
  logic      room;

  tos_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tos_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .room     (room),
    .push     (push)
  );

  tos_outq #(.DEPTH(QUEUE_DEPTH)) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/tos_cfg.sv */
// Configuration register file of the option stripper.
// Depends on tos_pkg for the register index codes and the tos_cfg_t bundle.
module tos_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_wdata,
  output tos_pkg::tos_cfg_t cfg
);
  import tos_pkg::*;

  tos_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind_list     <= '0;
      cfg_r.kind_count    <= '0;
      cfg_r.subtype_list  <= '0;
      cfg_r.subtype_count <= '0;
      cfg_r.strip_on_syn  <= 1'b1;
      cfg_r.strip_on_data <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KIND_LIST:     cfg_r.kind_list     <= cfg_wdata;
        CFG_KIND_COUNT:    cfg_r.kind_count    <= cfg_wdata[3:0];
        CFG_SUBTYPE_LIST:  cfg_r.subtype_list  <= cfg_wdata[31:0];
        CFG_SUBTYPE_COUNT: cfg_r.subtype_count <= cfg_wdata[3:0];
        CFG_STRIP_SYN:     cfg_r.strip_on_syn  <= cfg_wdata[0];
        CFG_STRIP_DATA:    cfg_r.strip_on_data <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/tos_parse.sv */
// Input register, option parser state and per-byte result generation.
// Depends on tos_pkg; produces up to three results per byte for the queue.
module tos_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tos_pkg::tos_in_t   in_data,
  input  tos_pkg::tos_cfg_t  cfg,
  input  logic               room,
  output tos_pkg::tos_push_t push
);
  import tos_pkg::*;

  tos_in_t    in_r;
  logic       in_vld_r;
  logic       fire;

  logic [5:0] area_r, area_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [5:0] left_r, left_nxt;
  phase_t     phase_r, phase_nxt;
  logic       rmv_r, rmv_nxt;
  logic       pass_r, pass_nxt;
  logic [7:0] hold0_r, hold0_nxt;
  logic [7:0] hold1_r, hold1_nxt;
  tos_push_t  res;

  assign fire     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  always_comb begin : parse
    logic       last;
    logic       rm;
    logic [5:0] pos;
    logic [5:0] alen;
    logic [7:0] b;
    logic [8:0] end_pos;
    area_nxt  = area_r;
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    phase_nxt = phase_r;
    rmv_nxt   = rmv_r;
    pass_nxt  = pass_r;
    hold0_nxt = hold0_r;
    hold1_nxt = hold1_r;
    res       = '0;
    b         = in_r.data_byte;
    alen      = in_r.area_len;
    last      = 1'b0;
    rm        = 1'b0;
    end_pos   = '0;
    pos       = '0;

    if (in_r.seg_start) begin
      // flush bytes still held from a segment that was cut short
      if (pos_r < area_r) begin
        if (phase_r == PH_LEN) begin
          res.res[res.cnt] = mk_res(hold0_r, 1'b1, 1'b0);
          res.cnt = res.cnt + 2'd1;
        end else if (phase_r == PH_SUB) begin
          res.res[res.cnt] = mk_res(hold0_r, 1'b0, 1'b0);
          res.cnt = res.cnt + 2'd1;
          res.res[res.cnt] = mk_res(hold1_r, 1'b1, 1'b0);
          res.cnt = res.cnt + 2'd1;
        end
      end
      if (alen == 6'd0) alen = 6'd1;
      if (alen > MAX_AREA) alen = MAX_AREA;
      area_nxt  = alen;
      pos_nxt   = '0;
      left_nxt  = '0;
      phase_nxt = PH_KIND;
      rmv_nxt   = 1'b0;
      pass_nxt  = !((in_r.syn_flag && cfg.strip_on_syn) ||
                    (!in_r.syn_flag && cfg.strip_on_data));
    end

    if (pos_nxt >= area_nxt) begin
      res.res[res.cnt] = mk_res(b, 1'b0, 1'b0);
      res.cnt = res.cnt + 2'd1;
    end else begin
      pos     = pos_nxt;
      last    = (pos + 6'd1 == area_nxt);
      pos_nxt = pos + 6'd1;
      if (pass_nxt) begin
        res.res[res.cnt] = mk_res(b, last, 1'b0);
        res.cnt = res.cnt + 2'd1;
        phase_nxt = PH_KIND;
      end else begin
        unique case (phase_nxt)
          PH_KIND: begin
            if (b == EOL_BYTE) begin
              res.res[res.cnt] = mk_res(b, last, 1'b0);
              res.cnt = res.cnt + 2'd1;
              pass_nxt = 1'b1;
            end else if (b == NOP_BYTE) begin
              res.res[res.cnt] = mk_res(b, last, 1'b0);
              res.cnt = res.cnt + 2'd1;
            end else if (last) begin
              res.res[res.cnt] = mk_res(b, 1'b1, 1'b0);
              res.cnt = res.cnt + 2'd1;
              pass_nxt = 1'b1;
            end else begin
              hold0_nxt = b;
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            end_pos = {3'b000, pos} - 9'd1 + {1'b0, b};
            if (b < 8'd2 || end_pos > {3'b000, area_nxt}) begin
              res.res[res.cnt] = mk_res(hold0_nxt, 1'b0, 1'b0);
              res.cnt = res.cnt + 2'd1;
              res.res[res.cnt] = mk_res(b, last, 1'b0);
              res.cnt = res.cnt + 2'd1;
              pass_nxt  = 1'b1;
              phase_nxt = PH_KIND;
            end else if (hold0_nxt == MPTCP_KIND && cfg.subtype_count != 4'd0 &&
                         b >= 8'd3) begin
              hold1_nxt = b;
              left_nxt  = b[5:0] - 6'd2;
              phase_nxt = PH_SUB;
            end else begin
              rm = kind_hit(cfg.kind_list, cfg.kind_count, hold0_nxt);
              rmv_nxt = rm;
              res.res[res.cnt] = mk_res(hold0_nxt, 1'b0, rm);
              res.cnt = res.cnt + 2'd1;
              res.res[res.cnt] = mk_res(b, last, rm);
              res.cnt = res.cnt + 2'd1;
              left_nxt  = b[5:0] - 6'd2;
              phase_nxt = (left_nxt != 6'd0) ? PH_BODY : PH_KIND;
            end
          end
          PH_SUB: begin
            rm = kind_hit(cfg.kind_list, cfg.kind_count, hold0_nxt) ||
                 subtype_hit(cfg.subtype_list, cfg.subtype_count, b[7:4]);
            rmv_nxt = rm;
            res.res[res.cnt] = mk_res(hold0_nxt, 1'b0, rm);
            res.cnt = res.cnt + 2'd1;
            res.res[res.cnt] = mk_res(hold1_nxt, 1'b0, rm);
            res.cnt = res.cnt + 2'd1;
            res.res[res.cnt] = mk_res(b, last, rm);
            res.cnt = res.cnt + 2'd1;
            left_nxt  = (left_nxt != 6'd0) ? left_nxt - 6'd1 : 6'd0;
            phase_nxt = (left_nxt != 6'd0) ? PH_BODY : PH_KIND;
          end
          default: begin
            res.res[res.cnt] = mk_res(b, last, rmv_nxt);
            res.cnt = res.cnt + 2'd1;
            left_nxt = (left_nxt != 6'd0) ? left_nxt - 6'd1 : 6'd0;
            if (left_nxt == 6'd0) phase_nxt = PH_KIND;
          end
        endcase
      end
      if (last) phase_nxt = PH_KIND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      area_r   <= '0;
      pos_r    <= '0;
      left_r   <= '0;
      phase_r  <= PH_KIND;
      rmv_r    <= 1'b0;
      pass_r   <= 1'b0;
    end else begin
      in_vld_r <= (in_vld_r && !fire) || (in_valid && !in_stall);
      if (fire) begin
        area_r  <= area_nxt;
        pos_r   <= pos_nxt;
        left_r  <= left_nxt;
        phase_r <= phase_nxt;
        rmv_r   <= rmv_nxt;
        pass_r  <= pass_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_r <= in_data;
    if (fire) begin
      hold0_r <= hold0_nxt;
      hold1_r <= hold1_nxt;
    end
  end

  always_comb begin
    push     = res;
    push.cnt = fire ? res.cnt : 2'd0;
  end

endmodule

/* hw/rtl/tos_outq.sv */
// Result queue: takes up to three results per cycle, hands out one per cycle while out_stall is low.
// Depends on tos_pkg for the result and push bundles.
module tos_outq #(
  parameter int DEPTH = tos_pkg::OQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tos_pkg::tos_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output tos_pkg::tos_out_t  out_data
);
  import tos_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tos_out_t        mem [DEPTH];
  logic [AW-1:0]   head_r;
  logic [AW-1:0]   tail_r;
  logic [CW-1:0]   count_r;
  logic            pop;

  assign out_valid = count_r != '0;
  assign pop       = out_valid && !out_stall;
  assign room      = count_r <= CW'(DEPTH - 3);
  assign out_data  = mem[head_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_r + AW'(pop);
      tail_r  <= tail_r + AW'(push.cnt);
      count_r <= count_r + CW'(push.cnt) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push.cnt) mem[tail_r + AW'(k)] <= push.res[k];
    end
  end

endmodule

/* hw/rtl/tos_chk.sv */
// Port-level checks for tcp_option_stripper_core, attached by bind.
// Depends on tos_pkg for the result type and the NOP value.
module tos_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tos_pkg::tos_out_t out_data
);
  import tos_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  a_nop_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_changed |-> out_data.out_byte == NOP_BYTE)
    else $error("removed byte not replaced by NOP");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind tcp_option_stripper_core tos_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
